// File: hdl/fqs_pkg.sv
`default_nettype none
package fqs_pkg;

    // queue geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // field widths of the beats
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_SEARCH  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // one command beat
    typedef struct packed {
        cmd_t                      command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    // one result beat
    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] data;
        logic [POS_W-1:0]          found_index;
        logic [POS_W-1:0]          length;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic                      empty_res;
    } res_t;

    // store access from the sequencer
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    // finished result from the sequencer
    typedef struct packed {
        logic done;
        res_t item;
    } ctrl_res_t;

endpackage
`default_nettype wire

// File: hdl/fqs_store.sv
`default_nettype none
module fqs_store
(
    input  wire logic                           clk,
    input  wire fqs_pkg::mem_req_t              mem_req,
    output logic [fqs_pkg::DATA_WIDTH-1:0]      rd_data
);

    logic [fqs_pkg::DATA_WIDTH-1:0] mem_reg [fqs_pkg::DEPTH];
    logic [fqs_pkg::DATA_WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_reg[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data_reg <= mem_reg[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hdl/fqs_ctrl.sv
`default_nettype none
module fqs_ctrl
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire fqs_pkg::req_t                  req,
    input  wire logic [fqs_pkg::DATA_WIDTH-1:0] rd_data,
    output logic                                busy,
    output fqs_pkg::mem_req_t                   mem_req,
    output fqs_pkg::ctrl_res_t                  ctrl_res
);

    localparam int ADDR_W = fqs_pkg::ADDR_W;
    localparam int CNT_W  = fqs_pkg::CNT_W;
    localparam int DW     = fqs_pkg::DATA_WIDTH;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_OP    = 8'b0000_0010,
        S_DEQ   = 8'b0000_0100,
        S_FIND  = 8'b0000_1000,
        S_SRCH  = 8'b0001_0000,
        S_FRONT = 8'b0010_0000,
        S_REAR  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [ADDR_W-1:0]             head_reg, head_next;
    logic [ADDR_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ADDR_W-1:0]             idx_reg, idx_next;
    fqs_pkg::cmd_t                 cmd_reg;
    logic [DW-1:0]                 key_reg;
    logic [fqs_pkg::POS_W-1:0]     pos_reg;
    fqs_pkg::status_t              status_reg, status_next;
    logic [DW-1:0]                 data_reg, data_next;
    logic [CNT_W-1:0]              found_reg, found_next;
    logic [DW-1:0]                 front_reg, front_next;

    logic [ADDR_W-1:0]             offset;
    logic [ADDR_W:0]               addr_sum;
    logic [ADDR_W-1:0]             ring_addr;
    logic [CNT_W-1:0]              idx_inc;
    logic                          key_match;
    logic                          pos_bad;
    logic                          q_full;
    logic                          q_empty;

    // ring address: head plus offset, wrapped once
    always_comb
    begin
        addr_sum = {1'b0, head_reg} + {1'b0, offset};
        if (32'(addr_sum) >= fqs_pkg::DEPTH)
        begin
            ring_addr = ADDR_W'(32'(addr_sum) - fqs_pkg::DEPTH);
        end
        else
        begin
            ring_addr = addr_sum[ADDR_W-1:0];
        end
    end

    // shared compare unit and flags
    assign key_match = (rd_data == key_reg);
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign q_full    = (32'(count_reg) >= fqs_pkg::DEPTH);
    assign q_empty   = (count_reg == '0);
    assign pos_bad   = (pos_reg == '0) || (32'(pos_reg) > 32'(count_reg));

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        front_next  = front_reg;
        offset      = '0;
        mem_req     = '0;
        mem_req.waddr = tail_reg;
        mem_req.wdata = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                status_next = fqs_pkg::ST_OK;
                data_next   = '0;
                found_next  = '0;
                idx_next    = '0;
                state_next  = S_FRONT;
                case (cmd_reg)
                    fqs_pkg::CMD_ENQUEUE:
                    begin
                        if (q_full)
                        begin
                            status_next = fqs_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_req.we = 1'b1;
                            tail_next  = (32'(tail_reg) == fqs_pkg::DEPTH - 1) ?
                                         '0 : tail_reg + ADDR_W'(1);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    fqs_pkg::CMD_DEQUEUE:
                    begin
                        if (q_empty)
                        begin
                            status_next = fqs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_req.re = 1'b1;
                            state_next = S_DEQ;
                        end
                    end
                    fqs_pkg::CMD_FIND:
                    begin
                        if (pos_bad)
                        begin
                            status_next = fqs_pkg::ST_BAD_POS;
                        end
                        else
                        begin
                            offset     = ADDR_W'(pos_reg - fqs_pkg::POS_W'(1));
                            mem_req.re = 1'b1;
                            state_next = S_FIND;
                        end
                    end
                    default:
                    begin
                        status_next = fqs_pkg::ST_NOT_FOUND;
                        if (!q_empty)
                        begin
                            mem_req.re = 1'b1;
                            state_next = S_SRCH;
                        end
                    end
                endcase
            end
            S_DEQ:
            begin
                data_next  = rd_data;
                head_next  = (32'(head_reg) == fqs_pkg::DEPTH - 1) ?
                             '0 : head_reg + ADDR_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = S_FRONT;
            end
            S_FIND:
            begin
                data_next  = rd_data;
                state_next = S_FRONT;
            end
            S_SRCH:
            begin
                // data for offset idx arrives while offset idx+1 is fetched
                offset     = idx_inc[ADDR_W-1:0];
                mem_req.re = 1'b1;
                if (key_match)
                begin
                    status_next = fqs_pkg::ST_OK;
                    found_next  = idx_inc;
                    state_next  = S_FRONT;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = S_FRONT;
                end
                else
                begin
                    idx_next = idx_inc[ADDR_W-1:0];
                end
            end
            S_FRONT:
            begin
                mem_req.re = 1'b1;
                state_next = S_REAR;
            end
            S_REAR:
            begin
                front_next = rd_data;
                offset     = ADDR_W'(count_reg - CNT_W'(1));
                mem_req.re = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mem_req.raddr = ring_addr;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        front_reg  <= front_next;
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= req.command;
            key_reg <= DW'(req.value);
            pos_reg <= req.position;
        end
    end

    // result assembly
    always_comb
    begin
        ctrl_res                  = '0;
        ctrl_res.done             = (state_reg == S_DONE);
        ctrl_res.item.status      = status_reg;
        ctrl_res.item.data        = fqs_pkg::VALUE_W'($signed(data_reg));
        ctrl_res.item.found_index = fqs_pkg::POS_W'(found_reg);
        ctrl_res.item.length      = fqs_pkg::POS_W'(count_reg);
        ctrl_res.item.front_value = q_empty ? '0 : fqs_pkg::VALUE_W'($signed(front_reg));
        ctrl_res.item.rear_value  = q_empty ? '0 : fqs_pkg::VALUE_W'($signed(rd_data));
        ctrl_res.item.empty_res   = q_empty;
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // count never passes the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= fqs_pkg::DEPTH)
        else $error("entry count beyond ring size");

    // tail always sits count entries past head
    assert property (@(posedge clk) disable iff (!rst_n)
        ((32'(head_reg) + 32'(count_reg)) % fqs_pkg::DEPTH) == 32'(tail_reg))
        else $error("head, tail and count disagree");

    // a write only ever lands in a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("store written without count growing");
`endif

endmodule
`default_nettype wire

// File: hdl/fifo_queue_with_search_unit.sv
`default_nettype none
// Bounded FIFO queue of fqs_pkg::DEPTH entries held in a ring store with one
// write port and one read port, taking one command per beat: enqueue,
// dequeue, find by 1-based position, or search for the first entry equal to
// a value. A command is taken when start is high and busy is low; busy then
// stays high until the result is out. Each result beat shows on result for
// exactly one cycle with done high and cannot be held off, so the receiver
// must take it then. The search loop reads and compares one stored entry per
// cycle through the one store read port, and the front and rear values of
// every result are two more reads on that port.
module fifo_queue_with_search_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire fqs_pkg::req_t  req,
    output logic                busy,
    output logic                done,
    output fqs_pkg::res_t       result
);

    fqs_pkg::mem_req_t              mem_req;
    logic [fqs_pkg::DATA_WIDTH-1:0] rd_data;
    fqs_pkg::ctrl_res_t             ctrl_res;
    logic                           done_reg;
    fqs_pkg::res_t                  result_reg;

    // sequencer with pointers and compare unit
    fqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .rd_data  (rd_data),
        .busy     (busy),
        .mem_req  (mem_req),
        .ctrl_res (ctrl_res)
    );

    // ring store
    fqs_store u_store
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_res.done;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (ctrl_res.done)
        begin
            result_reg <= ctrl_res.item;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // results never come on adjacent cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("back to back result beats");
`endif

endmodule
`default_nettype wire

// File: tb/sv/fifo_queue_with_search_unit_test.sv
`timescale 1ns / 1ps

module fifo_queue_with_search_unit_test;

    import fqs_pkg::*;

    localparam int RESET_CYCLES  = 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 1600;

    // mirror of the queue contents, predicting each result beat
    class queue_mirror;
        logic signed [VALUE_W-1:0] ring [DEPTH];
        int   head;
        int   tail;
        int   fill;
        res_t expected_results [$];
        int   failures;

        function new();
            head     = 0;
            tail     = 0;
            fill     = 0;
            failures = 0;
        endfunction

        // work out the result of an accepted command beat
        function void note_command(req_t cmd);
            res_t exp;
            int   i;
            exp        = '0;
            exp.status = ST_OK;
            case (cmd.command)
                CMD_ENQUEUE:
                begin
                    if (fill >= DEPTH)
                        exp.status = ST_FULL;
                    else
                    begin
                        ring[tail] = cmd.value;
                        tail       = (tail + 1) % DEPTH;
                        fill++;
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (fill == 0)
                        exp.status = ST_EMPTY;
                    else
                    begin
                        exp.data = ring[head];
                        head     = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                CMD_FIND:
                begin
                    if (int'(cmd.position) < 1 || int'(cmd.position) > fill)
                        exp.status = ST_BAD_POS;
                    else
                        exp.data = ring[(head + int'(cmd.position) - 1) % DEPTH];
                end
                default:
                begin
                    // first match from the front wins
                    exp.status = ST_NOT_FOUND;
                    for (i = 0; i < fill && exp.status == ST_NOT_FOUND; i++)
                    begin
                        if (ring[(head + i) % DEPTH] == cmd.value)
                        begin
                            exp.found_index = POS_W'(i + 1);
                            exp.status      = ST_OK;
                        end
                    end
                end
            endcase
            exp.length    = POS_W'(fill);
            exp.empty_res = (fill == 0);
            if (fill > 0)
            begin
                exp.front_value = ring[head];
                exp.rear_value  = ring[(head + fill - 1) % DEPTH];
            end
            expected_results.push_back(exp);
        endfunction

        // compare a result beat with the oldest prediction
        function void check_result(res_t got);
            res_t exp;
            bit   bad;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result beat: status=%0d data=%0d",
                             got.status, got.data);
                return;
            end
            exp = expected_results.pop_front();
            bad = (got.status      !== exp.status)      ||
                  (got.data        !== exp.data)        ||
                  (got.found_index !== exp.found_index) ||
                  (got.length      !== exp.length)      ||
                  (got.front_value !== exp.front_value) ||
                  (got.rear_value  !== exp.rear_value)  ||
                  (got.empty_res   !== exp.empty_res);
            if (bad)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("mismatch exp: st=%0d data=%0d idx=%0d len=%0d",
                             exp.status, exp.data, exp.found_index, exp.length);
                    $display("              front=%0d rear=%0d e=%0d",
                             exp.front_value, exp.rear_value, exp.empty_res);
                    $display("         got: st=%0d data=%0d idx=%0d len=%0d",
                             got.status, got.data, got.found_index, got.length);
                    $display("              front=%0d rear=%0d e=%0d",
                             got.front_value, got.rear_value, got.empty_res);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    res_t result;

    queue_mirror mirror;
    int          cycle_count;

    fifo_queue_with_search_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watch both sides of the block
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                mirror.check_result(result);
            if (start && !busy)
                mirror.note_command(req);
        end
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fifo_queue_with_search_unit_test: errors");
            $finish;
        end
    end

    function automatic req_t make_cmd(cmd_t c, logic signed [VALUE_W-1:0] v,
                                      logic [POS_W-1:0] p);
        req_t r;
        r.command  = c;
        r.value    = v;
        r.position = p;
        return r;
    endfunction

    // values drawn from a small pool so that searches hit, with extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return VALUE_W'($urandom_range(7));
        else if (sel < 75)
        begin
            case ($urandom_range(3))
                0:       return {1'b0, {(VALUE_W-1){1'b1}}};
                1:       return {1'b1, {(VALUE_W-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return VALUE_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(99) < 80)
            return POS_W'($urandom_range(17));
        return POS_W'($urandom_range(31));
    endfunction

    // present one command beat; the sender idles each cycle with the given odds
    task automatic issue(req_t r, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random walk that swings between filling and draining the queue
    task automatic run_random(int count, int idle_pct);
        bit   filling;
        int   sel;
        int   n;
        cmd_t c;
        filling = 1'b1;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(39) == 0)
                filling = ~filling;
            sel = $urandom_range(99);
            if (sel < 55)
                c = filling ? CMD_ENQUEUE : CMD_DEQUEUE;
            else if (sel < 70)
                c = filling ? CMD_DEQUEUE : CMD_ENQUEUE;
            else if (sel < 85)
                c = CMD_FIND;
            else
                c = CMD_SEARCH;
            issue(make_cmd(c, pick_value(), pick_position()), idle_pct);
        end
    endtask

    initial
    begin
        int waited;
        logic signed [VALUE_W-1:0] v_max;
        logic signed [VALUE_W-1:0] v_min;

        mirror      = new();
        cycle_count = 0;
        v_max       = {1'b0, {(VALUE_W-1){1'b1}}};
        v_min       = {1'b1, {(VALUE_W-1){1'b0}}};
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue cases, extremes, bad positions, last dequeue
        issue(make_cmd(CMD_DEQUEUE, '0, '0), 0);
        issue(make_cmd(CMD_SEARCH, '0, '0), 0);
        issue(make_cmd(CMD_FIND, '0, 5'd1), 0);
        issue(make_cmd(CMD_ENQUEUE, v_max, 5'd31), 0);
        issue(make_cmd(CMD_ENQUEUE, v_min, '0), 0);
        issue(make_cmd(CMD_ENQUEUE, '1, '0), 0);
        issue(make_cmd(CMD_SEARCH, v_min, '1), 0);
        issue(make_cmd(CMD_SEARCH, 32'sd12345, '0), 0);
        issue(make_cmd(CMD_FIND, '1, 5'd3), 0);
        issue(make_cmd(CMD_FIND, '0, 5'd0), 0);
        issue(make_cmd(CMD_FIND, '0, 5'd4), 0);
        issue(make_cmd(CMD_FIND, '0, 5'd16), 0);
        issue(make_cmd(CMD_FIND, '0, 5'd31), 0);
        issue(make_cmd(CMD_DEQUEUE, '1, '1), 0);
        issue(make_cmd(CMD_DEQUEUE, '0, '0), 0);
        issue(make_cmd(CMD_DEQUEUE, '0, '0), 0);
        issue(make_cmd(CMD_DEQUEUE, '0, '0), 0);
        issue(make_cmd(CMD_SEARCH, '1, '0), 0);

        // random: sender idles now and then, then often, then never
        run_random(RANDOM_ITEMS / 3, 21);
        run_random(RANDOM_ITEMS / 3, 58);
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);
        start <= 1'b0;

        // wait for the outstanding results, then let the block settle
        waited = 0;
        while (mirror.expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        mirror.failures += mirror.expected_results.size();

        if (mirror.failures == 0)
            $display("fifo_queue_with_search_unit_test: clean");
        else
            $display("fifo_queue_with_search_unit_test: errors");
        $finish;
    end

endmodule

// File: fifo_queue_with_search_unit.f
hdl/fqs_pkg.sv
hdl/fqs_store.sv
hdl/fqs_ctrl.sv
hdl/fifo_queue_with_search_unit.sv
tb/sv/fifo_queue_with_search_unit_test.sv
